FILE: hw/rtl/bsm_pkg.sv
// shared constants and types for the bounding sphere merge block
// no dependencies; used by the top level
`default_nettype none

package bsm_pkg;

    // default coordinate width, signed Q16.16
    localparam int COORD_WIDTH_DEF = 32;

    // result classification
    typedef enum logic [1:0] {
        OUT_A_ENCLOSES = 2'd0,
        OUT_B_ENCLOSES = 2'd1,
        OUT_NEW        = 2'd2,
        OUT_SATURATED  = 2'd3
    } outcome_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bsm_sqrt.sv
// pipelined integer square root, one result bit per stage
// no dependencies; instantiated by bounding_sphere_merge_top
`default_nettype none

module bsm_sqrt #(
    parameter int IN_W   = 68,
    parameter int SIDE_W = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [IN_W-1:0]       in_data,
    input  wire logic [SIDE_W-1:0]     in_side,
    output logic                       out_valid,
    output logic [IN_W/2-1:0]          out_root,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int STEPS = IN_W / 2;
    localparam int REM_W = STEPS + 2;

    logic              v_reg    [STEPS];
    logic [IN_W-1:0]   n_reg    [STEPS];
    logic [REM_W-1:0]  rem_reg  [STEPS];
    logic [STEPS-1:0]  q_reg    [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic              prev_v;
        logic [IN_W-1:0]   prev_n;
        logic [REM_W-1:0]  prev_rem;
        logic [STEPS-1:0]  prev_q;
        logic [SIDE_W-1:0] prev_side;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [STEPS-1:0]  q_next;

        if (i == 0) begin : g_first
            assign prev_v    = in_valid;
            assign prev_n    = in_data;
            assign prev_rem  = '0;
            assign prev_q    = '0;
            assign prev_side = in_side;
        end
        else begin : g_rest
            assign prev_v    = v_reg[i-1];
            assign prev_n    = n_reg[i-1];
            assign prev_rem  = rem_reg[i-1];
            assign prev_q    = q_reg[i-1];
            assign prev_side = side_reg[i-1];
        end

        // bring down the next two bits, try (4q + 1)
        assign rem_sh   = {prev_rem[REM_W-3:0], prev_n[IN_W-1:IN_W-2]};
        assign trial    = {prev_q, 2'b01};
        assign ge       = (rem_sh >= trial);
        assign rem_next = ge ? (rem_sh - trial) : rem_sh;
        assign q_next   = {prev_q[STEPS-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= prev_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i]    <= {prev_n[IN_W-3:0], 2'b00};
                rem_reg[i]  <= rem_next;
                q_reg[i]    <= q_next;
                side_reg[i] <= prev_side;
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_root  = q_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/bsm_div.sv
// pipelined restoring divider, one quotient bit per stage
// no dependencies; instantiated by bounding_sphere_merge_top
`default_nettype none

module bsm_div #(
    parameter int NUM_W  = 66,
    parameter int DEN_W  = 33,
    parameter int QUO_W  = 33,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       out_quo,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int REM_W = DEN_W + 1;

    logic              v_reg    [QUO_W];
    logic [REM_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  lo_reg   [QUO_W];
    logic [QUO_W-1:0]  q_reg    [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_step
        logic              prev_v;
        logic [REM_W-1:0]  prev_rem;
        logic [QUO_W-1:0]  prev_lo;
        logic [QUO_W-1:0]  prev_q;
        logic [DEN_W-1:0]  prev_den;
        logic [SIDE_W-1:0] prev_side;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  den_ext;
        logic              ge;

        if (i == 0) begin : g_first
            assign prev_v    = in_valid;
            assign prev_rem  = REM_W'(in_num[NUM_W-1:QUO_W]);
            assign prev_lo   = in_num[QUO_W-1:0];
            assign prev_q    = '0;
            assign prev_den  = in_den;
            assign prev_side = in_side;
        end
        else begin : g_rest
            assign prev_v    = v_reg[i-1];
            assign prev_rem  = rem_reg[i-1];
            assign prev_lo   = lo_reg[i-1];
            assign prev_q    = q_reg[i-1];
            assign prev_den  = den_reg[i-1];
            assign prev_side = side_reg[i-1];
        end

        assign rem_sh  = {prev_rem[DEN_W-1:0], prev_lo[QUO_W-1]};
        assign den_ext = {1'b0, prev_den};
        assign ge      = (rem_sh >= den_ext);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= prev_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? (rem_sh - den_ext) : rem_sh;
                lo_reg[i]   <= {prev_lo[QUO_W-2:0], 1'b0};
                q_reg[i]    <= {prev_q[QUO_W-2:0], ge};
                den_reg[i]  <= prev_den;
                side_reg[i] <= prev_side;
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign out_quo   = q_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/bounding_sphere_merge_top.sv
// bounding sphere merge, top level: front end, root and divide pipelines, output stage
// depends on bsm_pkg, bsm_sqrt and bsm_div
//
// usage:
//   s_tvalid/s_tready/s_tdata carry one request: two spheres A and B (centers
//   in signed Q16.16, radii unsigned). m_tvalid/m_tready/m_tdata carry the
//   smallest sphere enclosing both plus an outcome code, exactly one result
//   per request, in request order.
//   the pipeline has three front stages, COORD_WIDTH+2 square root
//   stages, two stages for radius and products, COORD_WIDTH+1 divide
//   stages and the output register.
//   throughput is one request per cycle while results are taken; the
//   bit-per-stage root and divide pipelines set the depth, not the rate.
//   the whole pipeline moves on one enable; when the output register holds
//   a result that is not taken, every stage holds and s_tready drops, so
//   nothing is lost or repeated. a request is taken in the same cycle the
//   waiting result leaves.
//   reset clears the valid bits only; the payload registers are not reset.
`default_nettype none

module bounding_sphere_merge_top #(
    parameter int COORD_WIDTH = bsm_pkg::COORD_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius, zero pad
    input  wire logic [((8*COORD_WIDTH-2+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // out_x, out_y, out_z, out_radius, outcome, zero pad
    output logic [((4*COORD_WIDTH+1+7)/8)*8-1:0] m_tdata
);

    localparam int W      = COORD_WIDTH;
    localparam int OUT_DW = ((4*W+1+7)/8)*8;
    localparam int SQ_W   = 2*W + 2;    // square of a delta magnitude
    localparam int D2_W   = 2*W + 4;    // sum of three squares
    localparam int ROOT_W = D2_W / 2;

    // common fields carried along the pipeline
    typedef struct packed {
        logic                contain;
        logic                pick_a;
        logic [2:0][W-1:0]   a_c;
        logic [2:0][W-1:0]   b_c;
        logic [W-2:0]        ra;
        logic [W-2:0]        rb;
        logic [2:0]          neg;
        logic [2:0][W:0]     mag;
    } front_t;

    typedef struct packed {
        logic                contain;
        logic                pick_a;
        logic [2:0][W-1:0]   a_c;
        logic [2:0][W-1:0]   b_c;
        logic [W-2:0]        ra;
        logic [W-2:0]        rb;
        logic [W:0]          nr;
    } back_t;

    localparam int FRONT_W = $bits(front_t);
    localparam int BACK_W  = $bits(back_t);

    logic en;

    // stage 1: deltas, magnitudes, radius difference
    logic            v1_reg;
    front_t          f1_reg;
    logic [W-2:0]    rd1_reg;
    front_t          f1_next;
    logic [W-2:0]    rd1_next;

    // stage 2: squares
    logic                    v2_reg;
    front_t                  f2_reg;
    logic [2:0][SQ_W-1:0]    sq2_reg;
    logic [2*W-3:0]          rd2_reg;

    // stage 3: squared distance and containment test
    logic            v3_reg;
    front_t          f3_reg;
    front_t          f3_next;
    logic [D2_W-1:0] d2_3_reg;
    logic [D2_W-1:0] d2_next;

    // square root
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [FRONT_W-1:0] sq_side;
    front_t            f_sq;

    // stage 4: new radius and offset numerator
    logic         v4_reg;
    front_t       f4_reg;
    logic [W:0]   d4_reg;
    logic [W:0]   num4_reg;
    logic [W:0]   nr4_reg;
    logic [W+1:0] sum_next;
    logic [W:0]   nr_next;

    // stage 5: numerator products
    logic                 v5_reg;
    back_t                b5_reg;
    logic [2:0]           neg5_reg;
    logic [W:0]           d5_reg;
    logic [2:0][SQ_W-1:0] p5_reg;

    // divide lanes
    logic                    dv_x, dv_y, dv_z;
    logic [W:0]              off_x, off_y, off_z;
    logic [BACK_W:0]         side_x;
    logic                    side_y, side_z;
    back_t                   b_fin;
    logic [2:0]              neg_fin;
    logic [2:0][W:0]         off_fin;

    // output stage
    logic                m_tvalid_reg;
    logic [OUT_DW-1:0]   m_tdata_reg;
    logic [OUT_DW-1:0]   m_tdata_next;
    logic [2:0][W-1:0]   c_next;
    logic [W-2:0]        r_next;
    bsm_pkg::outcome_t   oc_next;

    assign en       = ~m_tvalid_reg | m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- stage 1 ----------------
    always_comb
    begin
        logic [W:0] dl;
        f1_next         = '0;
        f1_next.a_c[0]  = s_tdata[W-1:0];
        f1_next.a_c[1]  = s_tdata[2*W-1:W];
        f1_next.a_c[2]  = s_tdata[3*W-1:2*W];
        f1_next.ra      = s_tdata[4*W-2:3*W];
        f1_next.b_c[0]  = s_tdata[5*W-2:4*W-1];
        f1_next.b_c[1]  = s_tdata[6*W-2:5*W-1];
        f1_next.b_c[2]  = s_tdata[7*W-2:6*W-1];
        f1_next.rb      = s_tdata[8*W-3:7*W-1];
        for (int k = 0; k < 3; k++)
        begin
            dl = {f1_next.b_c[k][W-1], f1_next.b_c[k]}
               - {f1_next.a_c[k][W-1], f1_next.a_c[k]};
            f1_next.neg[k] = dl[W];
            f1_next.mag[k] = dl[W] ? (~dl + 1'b1) : dl;
        end
        // a wins ties
        f1_next.pick_a = (f1_next.ra >= f1_next.rb);
        rd1_next = f1_next.pick_a ? (f1_next.ra - f1_next.rb) : (f1_next.rb - f1_next.ra);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= sq_valid;
            v5_reg <= v4_reg;
            m_tvalid_reg <= dv_x;
        end
    end

    // ---------------- stage 3 comb ----------------
    assign d2_next = D2_W'(sq2_reg[0]) + D2_W'(sq2_reg[1]) + D2_W'(sq2_reg[2]);

    always_comb
    begin
        f3_next         = f2_reg;
        f3_next.contain = (d2_next <= D2_W'(rd2_reg));
    end

    // ---------------- stage 4 comb ----------------
    assign f_sq     = front_t'(sq_side);
    assign sum_next = (W+2)'(sq_root[W:0]) + (W+2)'(f_sq.ra) + (W+2)'(f_sq.rb);
    assign nr_next  = sum_next[W+1:1];

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg  <= f1_next;
            rd1_reg <= rd1_next;

            f2_reg  <= f1_reg;
            for (int k = 0; k < 3; k++)
            begin
                sq2_reg[k] <= f1_reg.mag[k] * f1_reg.mag[k];
            end
            rd2_reg <= rd1_reg * rd1_reg;

            f3_reg         <= f3_next;
            d2_3_reg       <= d2_next;

            f4_reg   <= f_sq;
            d4_reg   <= sq_root[W:0];
            nr4_reg  <= nr_next;
            num4_reg <= nr_next - (W+1)'(f_sq.ra);

            b5_reg.contain <= f4_reg.contain;
            b5_reg.pick_a  <= f4_reg.pick_a;
            b5_reg.a_c     <= f4_reg.a_c;
            b5_reg.b_c     <= f4_reg.b_c;
            b5_reg.ra      <= f4_reg.ra;
            b5_reg.rb      <= f4_reg.rb;
            b5_reg.nr      <= nr4_reg;
            neg5_reg       <= f4_reg.neg;
            d5_reg         <= d4_reg;
            for (int k = 0; k < 3; k++)
            begin
                p5_reg[k] <= f4_reg.mag[k] * num4_reg;
            end

            m_tdata_reg <= m_tdata_next;
        end
    end

    bsm_sqrt #(
        .IN_W   (D2_W),
        .SIDE_W (FRONT_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_data   (d2_3_reg),
        .in_side   (f3_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // x lane also carries the common fields
    bsm_div #(
        .NUM_W (SQ_W), .DEN_W (W+1), .QUO_W (W+1), .SIDE_W (BACK_W+1)
    ) u_div_x (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid  (v5_reg),
        .in_num    (p5_reg[0]),
        .in_den    (d5_reg),
        .in_side   ({b5_reg, neg5_reg[0]}),
        .out_valid (dv_x),
        .out_quo   (off_x),
        .out_side  (side_x)
    );

    bsm_div #(
        .NUM_W (SQ_W), .DEN_W (W+1), .QUO_W (W+1), .SIDE_W (1)
    ) u_div_y (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid  (v5_reg),
        .in_num    (p5_reg[1]),
        .in_den    (d5_reg),
        .in_side   (neg5_reg[1]),
        .out_valid (dv_y),
        .out_quo   (off_y),
        .out_side  (side_y)
    );

    bsm_div #(
        .NUM_W (SQ_W), .DEN_W (W+1), .QUO_W (W+1), .SIDE_W (1)
    ) u_div_z (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid  (v5_reg),
        .in_num    (p5_reg[2]),
        .in_den    (d5_reg),
        .in_side   (neg5_reg[2]),
        .out_valid (dv_z),
        .out_quo   (off_z),
        .out_side  (side_z)
    );

    // ---------------- output stage comb ----------------
    assign b_fin   = back_t'(side_x[BACK_W:1]);
    assign neg_fin = {side_z, side_y, side_x[0]};
    assign off_fin = {off_z, off_y, off_x};

    always_comb
    begin
        logic [W+1:0] a_ext;
        logic [W+1:0] c_wide;
        for (int k = 0; k < 3; k++)
        begin
            a_ext  = {{2{b_fin.a_c[k][W-1]}}, b_fin.a_c[k]};
            c_wide = neg_fin[k] ? (a_ext - (W+2)'(off_fin[k]))
                                : (a_ext + (W+2)'(off_fin[k]));
            c_next[k] = c_wide[W-1:0];
        end
        if (b_fin.contain)
        begin
            // one sphere already holds the other
            if (b_fin.pick_a)
            begin
                c_next  = b_fin.a_c;
                r_next  = b_fin.ra;
                oc_next = bsm_pkg::OUT_A_ENCLOSES;
            end
            else
            begin
                c_next  = b_fin.b_c;
                r_next  = b_fin.rb;
                oc_next = bsm_pkg::OUT_B_ENCLOSES;
            end
        end
        else if (b_fin.nr[W:W-1] != 2'b00)
        begin
            r_next  = '1;
            oc_next = bsm_pkg::OUT_SATURATED;
        end
        else
        begin
            r_next  = b_fin.nr[W-2:0];
            oc_next = bsm_pkg::OUT_NEW;
        end
        m_tdata_next = OUT_DW'({oc_next, r_next, c_next[2], c_next[1], c_next[0]});
    end

    // ---------------- checks ----------------
    // divide lanes run in lock step
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_x == dv_y) && (dv_x == dv_z))
    else $error("divide lanes out of step");

    // a new sphere always has a nonzero center distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !f4_reg.contain) |-> (d4_reg != '0))
    else $error("zero distance in new sphere case");

    // offset fraction never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !f4_reg.contain) |-> (num4_reg <= d4_reg))
    else $error("offset numerator above distance");

    // saturated outcome carries the maximum radius
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[4*W:4*W-1] == bsm_pkg::OUT_SATURATED))
            |-> (m_tdata[4*W-2:3*W] == '1))
    else $error("saturated radius not at maximum");

endmodule

`default_nettype wire
